@@ rtl/core/assert_macros.svh @@
// assertion macros for the asserting rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent must hold the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

@@ rtl/core/sha1nm_pkg.sv @@
// types and constants for the sha-1 nonce match search
`timescale 1ns / 1ps

package sha1nm_pkg;

	localparam int ROUNDS = 80;
	localparam logic [7:0] MAX_MATCH = 8'd160;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_01   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_23   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_45   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_67   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_23 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_4  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFICULTY = 3'd7;

	// round function selection
	localparam logic [1:0] F_CH  = 2'd0;
	localparam logic [1:0] F_PAR = 2'd1;
	localparam logic [1:0] F_MAJ = 2'd2;

	localparam logic [31:0] ROUND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	localparam logic [31:0] INIT_H [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [31:0] LEN_WORD = 32'h00000100;

	typedef struct packed {
		logic [63:0] nonce;
		logic [63:0] job_tag;
	} cand_t;

	typedef struct packed {
		logic [63:0] found_nonce;
		logic [7:0]  prefix_len;
		logic [31:0] digest_w0;
		logic [31:0] digest_w1;
		logic [31:0] digest_w2;
		logic [31:0] digest_w3;
		logic [31:0] digest_w4;
		logic [63:0] result_tag;
	} hit_t;

	// working variables plus the sliding 16-word schedule window
	typedef struct packed {
		logic [31:0]       a;
		logic [31:0]       b;
		logic [31:0]       c;
		logic [31:0]       d;
		logic [31:0]       e;
		logic [15:0][31:0] w;
		logic [63:0]       nonce;
		logic [63:0]       tag;
	} round_state_t;

	typedef struct packed {
		logic [4:0][31:0] word;
	} target_t;

endpackage

@@ rtl/core/sha1nm_round_cell.sv @@
// one sha-1 round cell of the unrolled chain
`timescale 1ns / 1ps

module sha1nm_round_cell #(
	parameter int ROUND = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     up_valid,
	input  sha1nm_pkg::round_state_t up,
	output logic                     dn_valid,
	output sha1nm_pkg::round_state_t dn
);

	localparam logic [1:0] KSEL = 2'(ROUND / 20);
	localparam logic [31:0] K = sha1nm_pkg::ROUND_K[KSEL];
	localparam logic [1:0] FSEL = (ROUND < 20) ? sha1nm_pkg::F_CH :
		((ROUND >= 40 && ROUND < 60) ? sha1nm_pkg::F_MAJ : sha1nm_pkg::F_PAR);

	logic                     valid_q;
	sha1nm_pkg::round_state_t st_q;
	sha1nm_pkg::round_state_t st_d;
	logic [31:0]              f;
	logic [31:0]              sched;

	always_comb begin
		case (FSEL)
			sha1nm_pkg::F_CH: begin
				f = (up.b & up.c) | (~up.b & up.d);
			end
			sha1nm_pkg::F_MAJ: begin
				f = (up.b & up.c) | (up.b & up.d) | (up.c & up.d);
			end
			default: begin
				f = up.b ^ up.c ^ up.d;
			end
		endcase
	end

	// next schedule word enters at the top of the window
	assign sched = up.w[13] ^ up.w[8] ^ up.w[2] ^ up.w[0];

	always_comb begin
		st_d       = up;
		st_d.a     = {up.a[26:0], up.a[31:27]} + f + up.e + K + up.w[0];
		st_d.b     = up.a;
		st_d.c     = {up.b[1:0], up.b[31:2]};
		st_d.d     = up.c;
		st_d.e     = up.d;
		st_d.w     = {{sched[30:0], sched[31]}, up.w[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= st_d;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = st_q;

endmodule

@@ rtl/core/sha1nm_finish.sv @@
// digest feed-forward, match count against the target and difficulty filter
`timescale 1ns / 1ps

module sha1nm_finish (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     up_valid,
	input  sha1nm_pkg::round_state_t up,
	input  sha1nm_pkg::target_t      target,
	input  logic [7:0]               difficulty,
	output logic                     dn_valid,
	output sha1nm_pkg::hit_t         dn
);

	logic             valid_s1;
	logic [4:0][31:0] dig_s1;
	logic [63:0]      nonce_s1;
	logic [63:0]      tag_s1;

	logic             valid_s2;
	sha1nm_pkg::hit_t hit_s2;

	logic [4:0][31:0] diff;
	logic [7:0]       match;

	// leading zeros of a nonzero word, binary search
	function automatic logic [4:0] clz32(input logic [31:0] x);
		logic [31:0] v;
		logic [4:0]  n;
		begin
			v = x;
			n = 5'd0;
			if (v[31:16] == 16'd0) begin
				n[4] = 1'b1;
				v    = {v[15:0], 16'd0};
			end
			if (v[31:24] == 8'd0) begin
				n[3] = 1'b1;
				v    = {v[23:0], 8'd0};
			end
			if (v[31:28] == 4'd0) begin
				n[2] = 1'b1;
				v    = {v[27:0], 4'd0};
			end
			if (v[31:30] == 2'd0) begin
				n[1] = 1'b1;
				v    = {v[29:0], 2'd0};
			end
			if (v[31] == 1'b0) begin
				n[0] = 1'b1;
			end
			return n;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1 && (match >= difficulty);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dig_s1[0] <= up.a + sha1nm_pkg::INIT_H[0];
			dig_s1[1] <= up.b + sha1nm_pkg::INIT_H[1];
			dig_s1[2] <= up.c + sha1nm_pkg::INIT_H[2];
			dig_s1[3] <= up.d + sha1nm_pkg::INIT_H[3];
			dig_s1[4] <= up.e + sha1nm_pkg::INIT_H[4];
			nonce_s1  <= up.nonce;
			tag_s1    <= up.tag;
		end
	end

	assign diff = dig_s1 ^ target.word;

	// first differing word decides, word 0 msb first
	always_comb begin
		match = sha1nm_pkg::MAX_MATCH;
		for (int i = 4; i >= 0; i--) begin
			if (diff[i] != 32'd0) begin
				match = {3'(i), 5'd0} + {3'd0, clz32(diff[i])};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2.found_nonce <= nonce_s1;
			hit_s2.prefix_len  <= match;
			hit_s2.digest_w0   <= dig_s1[0];
			hit_s2.digest_w1   <= dig_s1[1];
			hit_s2.digest_w2   <= dig_s1[2];
			hit_s2.digest_w3   <= dig_s1[3];
			hit_s2.digest_w4   <= dig_s1[4];
			hit_s2.result_tag  <= tag_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn       = hit_s2;

endmodule

@@ rtl/core/sha1nm_top_doc_placeholder.sv @@
// sha-1 nonce match search top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one candidate beat per cycle while cand_stall is low. Each nonzero nonce runs
// through a chain of 80 sha-1 round cells, one round per cell, then two finishing
// stages (digest add, then match count and difficulty check) and an output register.
// Candidates that miss the difficulty, and zero nonces, leave no result and take no
// output slot. The whole chain holds only while a result sits in the output register
// under stall and another result is ready behind it; then cand_stall is high. There is
// no start-up sweep: configuration writes take effect at once and must be made while
// nothing is in flight.
module sha1_nonce_match_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sha1nm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                         cfg_data,
	input  logic                                cand_valid,
	output logic                                cand_stall,
	input  sha1nm_pkg::cand_t                   cand,
	output logic                                hit_valid,
	input  logic                                hit_stall,
	output sha1nm_pkg::hit_t                    hit
);

	localparam int N = sha1nm_pkg::ROUNDS;

	logic [63:0] base_01_q;
	logic [63:0] base_23_q;
	logic [63:0] base_45_q;
	logic [63:0] base_67_q;
	logic [63:0] target_01_q;
	logic [63:0] target_23_q;
	logic [31:0] target_4_q;
	logic [7:0]  difficulty_q;

	sha1nm_pkg::round_state_t chain [N+1];
	logic [N:0]               chain_valid;
	sha1nm_pkg::target_t      target;

	logic             en;
	logic             fin_valid;
	sha1nm_pkg::hit_t fin;
	logic             hit_valid_q;
	sha1nm_pkg::hit_t hit_q;

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_01_q    <= 64'd0;
			base_23_q    <= 64'd0;
			base_45_q    <= 64'd0;
			base_67_q    <= 64'd0;
			target_01_q  <= 64'd0;
			target_23_q  <= 64'd0;
			target_4_q   <= 32'd0;
			difficulty_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				sha1nm_pkg::CFG_BASE_01:    base_01_q    <= cfg_data;
				sha1nm_pkg::CFG_BASE_23:    base_23_q    <= cfg_data;
				sha1nm_pkg::CFG_BASE_45:    base_45_q    <= cfg_data;
				sha1nm_pkg::CFG_BASE_67:    base_67_q    <= cfg_data;
				sha1nm_pkg::CFG_TARGET_01:  target_01_q  <= cfg_data;
				sha1nm_pkg::CFG_TARGET_23:  target_23_q  <= cfg_data;
				sha1nm_pkg::CFG_TARGET_4:   target_4_q   <= cfg_data[31:0];
				sha1nm_pkg::CFG_DIFFICULTY: difficulty_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign target.word[0] = target_01_q[63:32];
	assign target.word[1] = target_01_q[31:0];
	assign target.word[2] = target_23_q[63:32];
	assign target.word[3] = target_23_q[31:0];
	assign target.word[4] = target_4_q;

	// chain holds only when a second result would collide with a stalled one
	assign en         = !(fin_valid && hit_valid_q && hit_stall);
	assign cand_stall = !en;

	// message block: swapped base words, nonce folded into words 6 and 7, padding
	always_comb begin
		chain[0].a     = sha1nm_pkg::INIT_H[0];
		chain[0].b     = sha1nm_pkg::INIT_H[1];
		chain[0].c     = sha1nm_pkg::INIT_H[2];
		chain[0].d     = sha1nm_pkg::INIT_H[3];
		chain[0].e     = sha1nm_pkg::INIT_H[4];
		chain[0].w     = '0;
		chain[0].w[0]  = swap32(base_01_q[63:32]);
		chain[0].w[1]  = swap32(base_01_q[31:0]);
		chain[0].w[2]  = swap32(base_23_q[63:32]);
		chain[0].w[3]  = swap32(base_23_q[31:0]);
		chain[0].w[4]  = swap32(base_45_q[63:32]);
		chain[0].w[5]  = swap32(base_45_q[31:0]);
		chain[0].w[6]  = swap32(base_67_q[63:32]) ^ cand.nonce[63:32];
		chain[0].w[7]  = swap32(base_67_q[31:0]) ^ cand.nonce[31:0];
		chain[0].w[8]  = sha1nm_pkg::PAD_WORD;
		chain[0].w[15] = sha1nm_pkg::LEN_WORD;
		chain[0].nonce = cand.nonce;
		chain[0].tag   = cand.job_tag;
	end

	// zero nonce is accepted but never enters the chain
	assign chain_valid[0] = cand_valid && (cand.nonce != 64'd0);

	for (genvar gi = 0; gi < N; gi++) begin : g_round
		sha1nm_round_cell #(
			.ROUND(gi)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.up_valid(chain_valid[gi]),
			.up      (chain[gi]),
			.dn_valid(chain_valid[gi+1]),
			.dn      (chain[gi+1])
		);
	end

	sha1nm_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.up_valid  (chain_valid[N]),
		.up        (chain[N]),
		.target    (target),
		.difficulty(difficulty_q),
		.dn_valid  (fin_valid),
		.dn        (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
		end else begin
			hit_valid_q <= (en && fin_valid) || (hit_valid_q && hit_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (en && fin_valid) begin
			hit_q <= fin;
		end
	end

	assign hit_valid = hit_valid_q;
	assign hit       = hit_q;

	`ASSERT_ALWAYS(a_hold_only_when_full, !cand_stall || (hit_valid && hit_stall), "bad hold")
	`ASSERT_ALWAYS(a_no_zero_nonce, !hit_valid || (hit.found_nonce != 64'd0), "zero nonce hit")
	`ASSERT_ALWAYS(a_match_range, !hit_valid || (hit.prefix_len <= sha1nm_pkg::MAX_MATCH), "count above 160")
	`ASSERT_NEXT(a_held_result_kept, cand_stall, fin_valid, "held result lost from finish stage")

endmodule

@@ verif/tb_sha1_nonce_match_search.sv @@
// self-checking testbench for the sha-1 nonce match search
`timescale 1ns / 1ps

module tb_sha1_nonce_match_search;
	import sha1nm_pkg::*;

	localparam int LATENCY = 83;
	localparam int SETTLE_GAP = LATENCY + 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 12;
	localparam int PRESS_PHASE = 8;
	localparam int RAND_ITEMS = 820;
	localparam int PRESS_ITEMS = 200;
	localparam logic [63:0] DIR_ANCHOR = 64'hDEAD_BEEF_0BAD_F00D;

	typedef enum logic {ROW_REG, ROW_CAND} row_kind_e;

	// data is the register value on register rows and the nonce on candidate rows
	typedef struct packed {
		row_kind_e              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [63:0]            data;
		logic [63:0]            tag;
		logic                   no_hit;
	} dir_row_t;

	localparam int DIR_ROWS = 31;

	// index is unused on candidate rows
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_CAND, CFG_BASE_01, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
		'{ROW_CAND, CFG_BASE_01, 64'h1, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0},
		'{ROW_REG, CFG_BASE_01, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
		'{ROW_REG, CFG_BASE_23, 64'h0123_4567_89AB_CDEF, 64'h0, 1'b0},
		'{ROW_REG, CFG_BASE_45, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
		'{ROW_REG, CFG_BASE_67, 64'h8000_0000_0000_0001, 64'h0, 1'b0},
		'{ROW_REG, CFG_TARGET_01, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
		'{ROW_REG, CFG_TARGET_23, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
		'{ROW_REG, CFG_TARGET_4, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
		// upper bits set, low byte zero: difficulty zero
		'{ROW_REG, CFG_DIFFICULTY, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h0, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1},
		'{ROW_CAND, CFG_BASE_01, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 1'b0},
		// difficulty beyond the digest width never hits
		'{ROW_REG, CFG_DIFFICULTY, 64'd161, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h1, 64'h1, 1'b1},
		'{ROW_CAND, CFG_BASE_01, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2, 1'b1},
		'{ROW_REG, CFG_DIFFICULTY, 64'd255, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h1234_5678_9ABC_DEF0, 64'h3, 1'b1},
		'{ROW_REG, CFG_DIFFICULTY, 64'd160, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h7, 64'h4, 1'b0},
		'{ROW_REG, CFG_TARGET_01, 64'h0, 64'h0, 1'b0},
		'{ROW_REG, CFG_TARGET_23, 64'h0, 64'h0, 1'b0},
		'{ROW_REG, CFG_TARGET_4, 64'h0, 64'h0, 1'b0},
		'{ROW_REG, CFG_DIFFICULTY, 64'd1, 64'h0, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'hFFFF_FFFF_0000_0000, 64'h5, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h2, 64'h6, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h3, 64'h7, 1'b0},
		'{ROW_CAND, CFG_BASE_01, 64'h0, 64'h8, 1'b1}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [63:0]            cfg_data;
	logic                   cand_valid;
	logic                   cand_stall;
	cand_t                  cand;
	logic                   hit_valid;
	logic                   hit_stall;
	hit_t                   hit;

	logic [63:0]    reg_mirror [8];
	hit_t           pending_hits [$];
	int             mismatches;
	int             quiet_cycles;
	int             send_idle_pct;
	int             recv_idle_pct;
	logic           hold_on;
	event           hold_go;

	sha1_nonce_match_search i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cand_valid (cand_valid),
		.cand_stall (cand_stall),
		.cand       (cand),
		.hit_valid  (hit_valid),
		.hit_stall  (hit_stall),
		.hit        (hit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one padded single-block sha-1 over the swapped base words with the nonce folded in
	function automatic logic [159:0] sha1_digest(input logic [63:0] nonce);
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, t, w;
		for (int j = 0; j < 8; j++) begin
			w = (j % 2) ? reg_mirror[CFG_BASE_01 + j / 2][31:0]
				: reg_mirror[CFG_BASE_01 + j / 2][63:32];
			sched[j] = {w[7:0], w[15:8], w[23:16], w[31:24]};
		end
		sched[6] = sched[6] ^ nonce[63:32];
		sched[7] = sched[7] ^ nonce[31:0];
		sched[8] = PAD_WORD;
		for (int j = 9; j < 15; j++)
			sched[j] = '0;
		sched[15] = LEN_WORD;
		for (int j = 16; j < ROUNDS; j++) begin
			w = sched[j-3] ^ sched[j-8] ^ sched[j-14] ^ sched[j-16];
			sched[j] = {w[30:0], w[31]};
		end
		a = INIT_H[0];
		b = INIT_H[1];
		c = INIT_H[2];
		d = INIT_H[3];
		e = INIT_H[4];
		for (int j = 0; j < ROUNDS; j++) begin
			if (j < 20)
				f = (b & c) | (~b & d);
			else if (j < 40)
				f = b ^ c ^ d;
			else if (j < 60)
				f = (b & c) | (b & d) | (c & d);
			else
				f = b ^ c ^ d;
			t = {a[26:0], a[31:27]} + f + e + ROUND_K[j / 20] + sched[j];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {a + INIT_H[0], b + INIT_H[1], c + INIT_H[2], d + INIT_H[3], e + INIT_H[4]};
	endfunction

	function automatic bit predict_hit(input cand_t c, output hit_t h);
		logic [159:0] dig, diff;
		logic [7:0] run;
		h = '0;
		if (c.nonce == '0)
			return 1'b0;
		dig = sha1_digest(c.nonce);
		diff = dig ^ {reg_mirror[CFG_TARGET_01], reg_mirror[CFG_TARGET_23],
			reg_mirror[CFG_TARGET_4][31:0]};
		run = MAX_MATCH;
		// the highest differing bit is the last one written
		for (int i = 0; i < 160; i++)
			if (diff[i])
				run = 8'(159 - i);
		if (run < reg_mirror[CFG_DIFFICULTY][7:0])
			return 1'b0;
		h.found_nonce = c.nonce;
		h.prefix_len = run;
		h.digest_w0 = dig[159:128];
		h.digest_w1 = dig[127:96];
		h.digest_w2 = dig[95:64];
		h.digest_w3 = dig[63:32];
		h.digest_w4 = dig[31:0];
		h.result_tag = c.job_tag;
		return 1'b1;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		reg_mirror[idx] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_cand(input cand_t c, input bit no_hit);
		hit_t h;
		while ($urandom_range(99) < send_idle_pct) begin
			cand_valid <= 1'b0;
			@(negedge clk);
		end
		cand_valid <= 1'b1;
		cand <= c;
		@(posedge clk);
		while (cand_stall)
			@(posedge clk);
		if (!no_hit && predict_hit(c, h))
			pending_hits.push_back(h);
		@(negedge clk);
	endtask

	// stop offering beats, wait out every expected hit and the misses still in flight
	task automatic quiesce();
		cand_valid <= 1'b0;
		@(negedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h actual %h", name, want, got);
		end
	endtask

	task automatic check_hit(input hit_t got);
		hit_t want;
		if (pending_hits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected hit: nonce %h tag %h", got.found_nonce, got.result_tag);
		end else begin
			want = pending_hits.pop_front();
			check_field("found_nonce", want.found_nonce, got.found_nonce);
			check_field("prefix_len", want.prefix_len, got.prefix_len);
			check_field("digest_w0", want.digest_w0, got.digest_w0);
			check_field("digest_w1", want.digest_w1, got.digest_w1);
			check_field("digest_w2", want.digest_w2, got.digest_w2);
			check_field("digest_w3", want.digest_w3, got.digest_w3);
			check_field("digest_w4", want.digest_w4, got.digest_w4);
			check_field("result_tag", want.result_tag, got.result_tag);
		end
	endtask

	always @(negedge clk)
		hit_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);

	// long back-pressure burst so the chain fills and stalls its input
	initial begin
		hold_on = 1'b0;
		forever begin
			@(hold_go);
			hold_on = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_on = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && hit_valid && !hit_stall)
			check_hit(hit);
		if ((cand_valid && !cand_stall) || (hit_valid && !hit_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		cand_t c;
		logic [63:0] anchor, nonce, data;
		logic [63:0] base_v [4];
		logic [159:0] tgt;
		int k, diff, sent, r, quota;
		bit dirty;

		mismatches = 0;
		quiet_cycles = 0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_01;
		cfg_data = '0;
		cand_valid = 1'b0;
		cand = '0;
		hit_stall = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 50;
		dirty = 1'b0;
		for (int i = 0; i < 8; i++)
			reg_mirror[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				if (dirty)
					quiesce();
				dirty = 1'b0;
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				c.nonce = dir_rows[i].data;
				c.job_tag = dir_rows[i].tag;
				send_cand(c, dir_rows[i].no_hit);
				dirty = 1'b1;
			end
		end

		// target set to the digest itself: full 160-bit match at the top difficulty
		quiesce();
		tgt = sha1_digest(DIR_ANCHOR);
		write_reg(CFG_TARGET_01, tgt[159:96]);
		write_reg(CFG_TARGET_23, tgt[95:32]);
		write_reg(CFG_TARGET_4, {32'h0, tgt[31:0]});
		write_reg(CFG_DIFFICULTY, {56'h0, MAX_MATCH});
		c.nonce = DIR_ANCHOR;
		c.job_tag = 64'hFEED_FACE_CAFE_BEEF;
		send_cand(c, 1'b0);
		c.nonce = DIR_ANCHOR ^ 64'h1;
		send_cand(c, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			send_idle_pct = (ph < 4) ? 38 : (ph < 8) ? 50 : 0;
			recv_idle_pct = (ph < 4) ? 50 : (ph < 8) ? 38 : 0;
			for (int j = 0; j < 4; j++)
				base_v[j] = (ph == 0) ? '0 : (ph == 1) ? '1 : {$urandom, $urandom};
			write_reg(CFG_BASE_01, base_v[0]);
			write_reg(CFG_BASE_23, base_v[1]);
			write_reg(CFG_BASE_45, base_v[2]);
			write_reg(CFG_BASE_67, base_v[3]);

			// target is the anchor's digest with bit k from the top flipped when k is below 160, so the anchor matches k bits
			anchor = {$urandom, $urandom};
			if (anchor == '0)
				anchor = 64'h1;
			tgt = sha1_digest(anchor);
			k = (ph >= 10) ? 160 : $urandom_range(0, 160);
			if (k < 160)
				tgt[159-k] = ~tgt[159-k];
			write_reg(CFG_TARGET_01, tgt[159:96]);
			write_reg(CFG_TARGET_23, tgt[95:32]);
			write_reg(CFG_TARGET_4, {$urandom, tgt[31:0]});

			case ($urandom_range(0, 9))
				5: diff = k;
				6: diff = k + 1;
				7: diff = 160;
				8: diff = $urandom_range(161, 255);
				9: diff = $urandom_range(4, 12);
				default: diff = $urandom_range(0, 3);
			endcase
			if (ph == PRESS_PHASE)
				diff = 0;
			if (ph == 10)
				diff = 160;
			if (ph == 11)
				diff = $urandom_range(161, 255);
			data = {$urandom, $urandom};
			data[7:0] = diff[7:0];
			write_reg(CFG_DIFFICULTY, data);

			// the pressure phase runs well past the chain depth so the input stalls
			quota = (ph == PRESS_PHASE) ? PRESS_ITEMS
				: (RAND_ITEMS - PRESS_ITEMS) / (PHASES - 1);
			if (ph == PRESS_PHASE)
				-> hold_go;
			sent = 0;
			while (sent < quota) begin
				r = $urandom_range(99);
				if (r < 12)
					nonce = anchor;
				else if (r < 17)
					nonce = '0;
				else if (r < 22)
					nonce = anchor ^ (64'h1 << $urandom_range(0, 63));
				else
					nonce = {$urandom, $urandom};
				c.nonce = nonce;
				c.job_tag = {$urandom, $urandom};
				send_cand(c, 1'b0);
				sent++;
			end
		end

		quiesce();
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
